// ===== rtl/ps2m_pkg.sv =====
// Shared types and constants for the PS/2 mouse cursor tracker.
package ps2m_pkg;

    localparam int unsigned POS_W    = 12;
    localparam int unsigned SCREEN_W = 13;
    localparam int unsigned DELTA_W  = 9;
    localparam int unsigned CURSOR_SZ_W = 7;

    localparam logic [POS_W-1:0]    POS_RESET    = 12'd100;
    localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 13'd768;

    // register indexes on the config port
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // what a queued word asks of the back end
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    typedef struct packed {
        logic [1:0]                kind;
        logic [2:0]                buttons;  // middle, right, left
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } q_entry_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } bounds_t;

    // Largest allowed position: screen - cursor - 1, held to 0 .. 4095.
    function automatic logic [POS_W-1:0] clamp_bound(
        input logic [SCREEN_W-1:0]    screen,
        input logic [CURSOR_SZ_W-1:0] cursor
    );
        logic signed [SCREEN_W+1:0] diff;
        diff = $signed({2'b00, screen}) - $signed({8'd0, cursor}) - 15'sd1;
        if (diff < 0) begin
            return '0;
        end else if (diff > $signed({3'b000, {POS_W{1'b1}}})) begin
            return {POS_W{1'b1}};
        end else begin
            return diff[POS_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/ps2_mouse_cursor_tracker.sv =====
// Path: each byte's result word is registered in the queue, then in stage 1, then in the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the 2-entry queue and the two
// back-end stages, which pass ready through so every stage moves each cycle unless m_ready holds it.
// Reset (aresetn, synchronous): phase to header byte, buttons and signs clear,
// cursor at (100, 100), screen size 1024 x 768, queue and output empty.
module ps2_mouse_cursor_tracker #(
    parameter int unsigned MOVE_DIVISOR = 1,
    parameter int unsigned CURSOR_W     = 16,
    parameter int unsigned CURSOR_H     = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_left_button,
    output logic                       m_right_button,
    output logic                       m_middle_button,
    output logic [ps2m_pkg::POS_W-1:0] m_cursor_x,
    output logic [ps2m_pkg::POS_W-1:0] m_cursor_y,
    output logic                       m_packet_done,
    output logic                       m_sync_error
);
    import ps2m_pkg::*;

    logic [SCREEN_W-1:0] width_reg, height_reg;
    logic                cfg_write;
    bounds_t             bounds;
    logic                q_push, q_full, q_valid, q_pop;
    q_entry_t            push_word, pop_word;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_SCREEN_WIDTH:  width_reg  <= pwdata[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: height_reg <= pwdata[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SCREEN_WIDTH:  prdata = {{(32-SCREEN_W){1'b0}}, width_reg};
            REG_SCREEN_HEIGHT: prdata = {{(32-SCREEN_W){1'b0}}, height_reg};
            default:           prdata = '0;
        endcase
    end

    // config must change only while idle (the block does not enforce it), so the bounds need no pipelining
    assign bounds.x = clamp_bound(width_reg, CURSOR_SZ_W'(CURSOR_W));
    assign bounds.y = clamp_bound(height_reg, CURSOR_SZ_W'(CURSOR_H));

    ps2m_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_push      (q_push),
        .q_word      (push_word),
        .q_full      (q_full)
    );

    ps2m_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_word  (pop_word),
        .pop       (q_pop)
    );

    ps2m_back #(
        .MOVE_DIVISOR (MOVE_DIVISOR)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_word          (pop_word),
        .q_pop           (q_pop),
        .bounds          (bounds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_button   (m_left_button),
        .m_right_button  (m_right_button),
        .m_middle_button (m_middle_button),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .m_packet_done   (m_packet_done),
        .m_sync_error    (m_sync_error)
    );

endmodule

// ===== rtl/ps2m_front.sv =====
// Front end: tracks the packet phase and turns each byte into a queue word.
module ps2m_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    output logic              q_push,
    output ps2m_pkg::q_entry_t q_word,
    input  logic              q_full
);
    import ps2m_pkg::*;

    localparam logic [1:0] PHASE_HDR = 2'd0;
    localparam logic [1:0] PHASE_X   = 2'd1;
    localparam logic [1:0] PHASE_Y   = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [2:0] buttons_reg, buttons_next;
    logic [1:0] signs_reg, signs_next;     // bit 0 X sign, bit 1 Y sign
    logic [7:0] held_x_reg, held_x_next;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        phase_next   = phase_reg;
        buttons_next = buttons_reg;
        signs_next   = signs_reg;
        held_x_next  = held_x_reg;
        q_word.kind  = KIND_NONE;
        q_word.dx    = $signed({signs_reg[0], held_x_reg});
        q_word.dy    = $signed({signs_reg[1], s_data_byte});
        unique case (phase_reg)
            PHASE_X: begin
                held_x_next = s_data_byte;
                phase_next  = PHASE_Y;
            end
            PHASE_Y: begin
                q_word.kind = KIND_MOVE;
                phase_next  = PHASE_HDR;
            end
            default: begin
                // header byte; unreachable phase three behaves the same
                buttons_next = s_data_byte[2:0];
                if (!s_data_byte[3]) begin
                    q_word.kind = KIND_ERR;
                    phase_next  = PHASE_HDR;
                end else begin
                    signs_next = s_data_byte[5:4];
                    phase_next = PHASE_X;
                end
            end
        endcase
        q_word.buttons = buttons_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PHASE_HDR;
            buttons_reg <= '0;
            signs_reg   <= '0;
            held_x_reg  <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            buttons_reg <= buttons_next;
            signs_reg   <= signs_next;
            held_x_reg  <= held_x_next;
        end
    end

endmodule

// ===== rtl/ps2m_queue.sv =====
// Two-entry queue between the byte front end and the cursor back end.
module ps2m_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ps2m_pkg::q_entry_t push_word,
    output logic               full,
    output logic               pop_valid,
    output ps2m_pkg::q_entry_t pop_word,
    input  logic               pop
);
    import ps2m_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    q_entry_t         store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_word  = store_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(DEPTH))
        else $error("queue fill count beyond depth");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");
`endif

endmodule

// ===== rtl/ps2m_back.sv =====
// Back end: scales deltas, updates and clamps the cursor, holds the result word.
module ps2m_back #(
    parameter int unsigned MOVE_DIVISOR = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  ps2m_pkg::q_entry_t              q_word,
    output logic                            q_pop,
    input  ps2m_pkg::bounds_t               bounds,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_left_button,
    output logic                            m_right_button,
    output logic                            m_middle_button,
    output logic [ps2m_pkg::POS_W-1:0]      m_cursor_x,
    output logic [ps2m_pkg::POS_W-1:0]      m_cursor_y,
    output logic                            m_packet_done,
    output logic                            m_sync_error
);
    import ps2m_pkg::*;

    // reciprocal is exact for magnitudes up to 256 and divisors up to 16
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned RECIP = ((1 << RECIP_SHIFT) + MOVE_DIVISOR - 1) / MOVE_DIVISOR;
    localparam int unsigned RECIP_W = RECIP_SHIFT + 1;
    localparam int unsigned PROD_W = DELTA_W + RECIP_W;
    localparam int unsigned SUM_W = POS_W + 2;

    function automatic logic signed [DELTA_W-1:0] scale(input logic signed [DELTA_W-1:0] d);
        logic [DELTA_W-1:0] mag;
        logic [PROD_W-1:0]  prod;
        logic [DELTA_W-1:0] q;
        mag  = d[DELTA_W-1] ? (~d + 1'b1) : d;
        prod = PROD_W'(mag) * PROD_W'(RECIP);
        q    = prod[RECIP_SHIFT +: DELTA_W];
        return d[DELTA_W-1] ? $signed(~q + 1'b1) : $signed(q);
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(
        input logic signed [SUM_W-1:0] p,
        input logic [POS_W-1:0]        hi
    );
        if (p < 0) begin
            return '0;
        end else if (p[SUM_W-2:0] > {1'b0, hi}) begin
            return hi;
        end else begin
            return p[POS_W-1:0];
        end
    endfunction

    // stage 1: scaled deltas
    logic                      s1_valid_reg;
    logic [1:0]                s1_kind_reg;
    logic [2:0]                s1_buttons_reg;
    logic signed [DELTA_W-1:0] s1_dx_reg, s1_dy_reg;
    logic                      s1_ready;
    logic                      out_load;

    logic [POS_W-1:0]          pos_x_reg, pos_y_reg;
    logic [POS_W-1:0]          pos_x_next, pos_y_next;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic                      s1_move;

    logic                      m_valid_reg;
    logic [2:0]                out_buttons_reg;
    logic [POS_W-1:0]          out_x_reg, out_y_reg;
    logic                      out_done_reg, out_err_reg;

    assign out_load = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s1_ready = !s1_valid_reg || out_load;
    assign q_pop    = q_valid && s1_ready;
    assign s1_move  = (s1_kind_reg == KIND_MOVE);

    assign sum_x = $signed({2'b00, pos_x_reg}) + SUM_W'(s1_dx_reg);
    assign sum_y = $signed({2'b00, pos_y_reg}) - SUM_W'(s1_dy_reg);

    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (s1_move) begin
            pos_x_next = clamp_pos(sum_x, bounds.x);
            pos_y_next = clamp_pos(sum_y, bounds.y);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_kind_reg    <= q_word.kind;
            s1_buttons_reg <= q_word.buttons;
            s1_dx_reg      <= scale(q_word.dx);
            s1_dy_reg      <= scale(q_word.dy);
        end
        if (out_load) begin
            out_buttons_reg <= s1_buttons_reg;
            out_x_reg       <= pos_x_next;
            out_y_reg       <= pos_y_next;
            out_done_reg    <= s1_move;
            out_err_reg     <= (s1_kind_reg == KIND_ERR);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pos_x_reg    <= POS_RESET;
            pos_y_reg    <= POS_RESET;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= q_valid;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                pos_x_reg   <= pos_x_next;
                pos_y_reg   <= pos_y_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_left_button   = out_buttons_reg[0];
    assign m_right_button  = out_buttons_reg[1];
    assign m_middle_button = out_buttons_reg[2];
    assign m_cursor_x      = out_x_reg;
    assign m_cursor_y      = out_y_reg;
    assign m_packet_done   = out_done_reg;
    assign m_sync_error    = out_err_reg;

`ifndef SYNTH
    a_done_err_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_done_reg && out_err_reg))
        else $error("packet done and sync error on one word");
    a_move_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_done_reg) |-> (out_x_reg <= bounds.x && out_y_reg <= bounds.y))
        else $error("cursor outside clamp bounds after a move");
    a_pos_only_on_move: assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_load && s1_move) |=> ($stable(pos_x_reg) && $stable(pos_y_reg)))
        else $error("cursor moved without a completed packet");
`endif

endmodule

// ===== dv/ps2_mouse_cursor_tracker_tb.sv =====
// Self-checking testbench for the PS/2 mouse cursor tracker: byte stream in, cursor words out.
module ps2_mouse_cursor_tracker_tb;
    import ps2m_pkg::*;

    localparam int MOVE_DIV = 1;
    localparam int CUR_W    = 16;
    localparam int CUR_H    = 16;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned TOTAL_BYTES  = 1700;
    localparam int unsigned MAX_PRINTS   = 40;

    localparam logic [2:0] ADDR_WIDTH  = {REG_SCREEN_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_HEIGHT = {REG_SCREEN_HEIGHT, 2'b00};

    // which byte of the packet comes next
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_XBYTE  = 2'd1;
    localparam logic [1:0] PH_YBYTE  = 2'd2;

    typedef struct packed {
        logic             left_btn;
        logic             right_btn;
        logic             middle_btn;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             done;
        logic             sync_err;
    } cursor_word_t;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_data_byte;
    logic                m_valid;
    logic                m_ready;
    logic                m_left_button;
    logic                m_right_button;
    logic                m_middle_button;
    logic [POS_W-1:0]    m_cursor_x;
    logic [POS_W-1:0]    m_cursor_y;
    logic                m_packet_done;
    logic                m_sync_error;

    ps2_mouse_cursor_tracker #(
        .MOVE_DIVISOR(MOVE_DIV),
        .CURSOR_W    (CUR_W),
        .CURSOR_H    (CUR_H)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_button  (m_left_button),
        .m_right_button (m_right_button),
        .m_middle_button(m_middle_button),
        .m_cursor_x     (m_cursor_x),
        .m_cursor_y     (m_cursor_y),
        .m_packet_done  (m_packet_done),
        .m_sync_error   (m_sync_error)
    );

    // tracker state as the testbench sees it
    logic [1:0]          phase;
    logic [2:0]          btns;
    logic [1:0]          signs;
    logic [7:0]          held_dx;
    logic [POS_W-1:0]    cur_x;
    logic [POS_W-1:0]    cur_y;
    logic [SCREEN_W-1:0] scr_w;
    logic [SCREEN_W-1:0] scr_h;

    cursor_word_t pending_words[$];

    bit          back_to_back;
    int unsigned mismatches;
    int unsigned n_bytes;
    int unsigned n_words;
    int unsigned n_packets;
    int unsigned n_drops;
    int unsigned n_settings;
    int unsigned cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     pending_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int scale_move(input logic [7:0] low8, input logic sgn);
        int d;
        d = int'(low8);
        if (sgn) d -= 256;
        return d / MOVE_DIV;  // truncates toward zero
    endfunction

    function automatic logic [POS_W-1:0] clamp_axis(input int p, input logic [SCREEN_W-1:0] screen,
                                                      input int csz);
        int lim;
        lim = int'(screen) - csz - 1;
        if (lim < 0) lim = 0;
        if (lim > 4095) lim = 4095;
        if (p < 0) p = 0;
        if (p > lim) p = lim;
        return p[POS_W-1:0];
    endfunction

    function automatic cursor_word_t track_byte(input logic [7:0] b);
        cursor_word_t w;
        int nx;
        int ny;
        w = '0;
        case (phase)
            PH_XBYTE: begin
                held_dx = b;
                phase = PH_YBYTE;
            end
            PH_YBYTE: begin
                nx = int'(cur_x) + scale_move(held_dx, signs[0]);
                ny = int'(cur_y) - scale_move(b, signs[1]);  // screen Y grows downward
                cur_x = clamp_axis(nx, scr_w, CUR_W);
                cur_y = clamp_axis(ny, scr_h, CUR_H);
                phase = PH_HEADER;
                w.done = 1'b1;
                n_packets++;
            end
            default: begin
                btns = b[2:0];
                if (!b[3]) begin
                    // buttons still taken, signs kept
                    w.sync_err = 1'b1;
                    phase = PH_HEADER;
                    n_drops++;
                end else begin
                    signs = b[5:4];
                    phase = PH_XBYTE;
                end
            end
        endcase
        w.left_btn   = btns[0];
        w.right_btn  = btns[1];
        w.middle_btn = btns[2];
        w.pos_x      = cur_x;
        w.pos_y      = cur_y;
        return w;
    endfunction

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at word %0d: %s got %0d, expected %0d", n_words, what, got, want);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report(what, got, want);
    endtask

    task automatic check_word();
        cursor_word_t want;
        if (pending_words.size() == 0) begin
            report("unexpected word, cursor_x", m_cursor_x, -1);
            return;
        end
        want = pending_words.pop_front();
        check_field("left_button", m_left_button, want.left_btn);
        check_field("right_button", m_right_button, want.right_btn);
        check_field("middle_button", m_middle_button, want.middle_btn);
        check_field("cursor_x", m_cursor_x, want.pos_x);
        check_field("cursor_y", m_cursor_y, want.pos_y);
        check_field("packet_done", m_packet_done, want.done);
        check_field("sync_error", m_sync_error, want.sync_err);
        n_words++;
    endtask

    initial begin : word_checker
        int unsigned stall;
        stall = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_word();
                stall = back_to_back ? 0 : $urandom_range(0, 19);
            end else if (stall != 0) begin
                stall--;
            end
            m_ready <= (stall == 0);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        pending_words.push_back(track_byte(b));
        n_bytes++;
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx, input logic [7:0] dy);
        send_byte(hdr);
        send_byte(dx);
        send_byte(dy);
    endtask

    // hold the sender off until every expected word is back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [SCREEN_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {19'($urandom), val};  // upper bits are junk the block must ignore
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [SCREEN_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field(addr == ADDR_WIDTH ? "screen_width readback" : "screen_height readback",
                    prdata, {19'd0, want});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_screen(input int w, input int h);
        wait_idle();
        apb_write(ADDR_WIDTH, w[SCREEN_W-1:0]);
        apb_write(ADDR_HEIGHT, h[SCREEN_W-1:0]);
        scr_w = w[SCREEN_W-1:0];
        scr_h = h[SCREEN_W-1:0];
        apb_check(ADDR_WIDTH, scr_w);
        apb_check(ADDR_HEIGHT, scr_h);
        n_settings++;
    endtask

    function automatic logic [7:0] rand_header();
        logic [7:0] h;
        h = 8'($urandom);
        h[3] = 1'b1;
        return h;
    endfunction

    // Defaults, then the reset position left unclamped under a tiny screen until a packet lands.
    task automatic test_reset_state();
        apb_check(ADDR_WIDTH, WIDTH_RESET);
        apb_check(ADDR_HEIGHT, HEIGHT_RESET);
        set_screen(32, 32);
        send_byte(8'h00);
        send_byte(8'h0F);
        send_byte(8'h00);
        send_byte(8'h00);
        set_screen(WIDTH_RESET, HEIGHT_RESET);
    endtask

    task automatic test_directed_bytes();
        logic [7:0] seq[] = '{
            8'h00,                  // no sync bit, nothing pressed
            8'h08, 8'h00, 8'h00,    // zero move
            8'hFF, 8'h00, 8'h00,    // all buttons, both signs, overflow set: -256 each way
            8'h08, 8'hFF, 8'hFF,    // +255 / +255
            8'h18, 8'h01, 8'h80,    // x -255, y +128
            8'hF7,                  // sync clear with high bits: signs must hold
            8'h28, 8'h7F, 8'h01,    // y -255 moves down the screen
            8'hC9, 8'h80, 8'h7F,
            8'h3C, 8'hFE, 8'hFE
        };
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Drive the cursor into both corners under extreme and degenerate screen sizes.
    task automatic test_screen_extremes();
        int sizes[6][2] = '{'{32, 4096}, '{4096, 32}, '{0, 17}, '{8191, 8191},
                            '{4112, 4113}, '{16, 8000}};
        logic [7:0] hdr;
        foreach (sizes[k]) begin
            set_screen(sizes[k][0], sizes[k][1]);
            repeat (18) begin
                hdr = rand_header();
                hdr[5:4] = 2'b10;
                send_packet(hdr, 8'hFF, 8'h01);
            end
            repeat (18) begin
                hdr = rand_header();
                hdr[5:4] = 2'b01;
                send_packet(hdr, 8'h00, 8'hFF);
            end
        end
    endtask

    task automatic test_random_stream();
        int unsigned pick;
        int unsigned last_cfg;
        int w;
        int h;
        last_cfg = n_bytes;
        set_screen($urandom_range(32, 4096), $urandom_range(32, 4096));
        while (n_bytes < TOTAL_BYTES) begin
            if (n_bytes % 100 < 3) back_to_back = ($urandom_range(0, 3) == 0);
            if (n_bytes - last_cfg >= 250) begin
                last_cfg = n_bytes;
                w = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(32, 4096);
                h = ($urandom_range(0, 4) == 0) ? 4096 : $urandom_range(32, 4096);
                set_screen(w, h);
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                send_packet(rand_header(), 8'($urandom), 8'($urandom));
            end else if (pick < 90) begin
                send_byte(8'($urandom) & 8'hF7);
            end else begin
                send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_valid      <= 1'b0;
        s_data_byte  <= '0;
        cycles       = 0;
        mismatches   = 0;
        n_bytes      = 0;
        n_words      = 0;
        n_packets    = 0;
        n_drops      = 0;
        n_settings   = 0;
        back_to_back = 1'b0;
        phase        = PH_HEADER;
        btns         = '0;
        signs        = '0;
        held_dx      = '0;
        cur_x        = POS_RESET;
        cur_y        = POS_RESET;
        scr_w        = WIDTH_RESET;
        scr_h        = HEIGHT_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_directed_bytes();
        test_screen_extremes();
        test_random_stream();

        wait_idle();
        // spare cycles to catch stray words
        repeat (8) @(posedge aclk);
        $display("%0d bytes in, %0d words checked: %0d packets, %0d dropped headers",
                 n_bytes, n_words, n_packets, n_drops);
        $display("%0d screen settings incl. zero and over-range clamp bounds, %0d mismatches",
                 n_settings, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
